>>> rtl/core/lsq_pkg.sv
package lsq_pkg;

	localparam int CFG_W  = 11;
	localparam int SIDE_W = 11;
	localparam int AREA_W = 21;

	localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 11'd1024;

	// per-cell control carried from the accept stage into the compute stage
	typedef struct packed {
		logic is_set;
		logic last;
		logic first;
		logic end_row;
	} cell_ctl_t;

endpackage

>>> rtl/core/largest_square_of_ones_unit.sv
// A result is registered through the accept, compute and output stages to out_valid.
// Throughput: one cell per cycle; the line buffer read is registered at accept for the
// compute stage with same-edge write forwarding, so rows of any width run unbroken.
// Input stalls only when a finished result is held and the next last cell meets it.
// Reset (arst_n low, asynchronous): pipeline empty, run state cleared, row_width = 1024;
// the line buffer is not cleared; its reads in a matrix's first row are masked to zero.
module largest_square_of_ones_unit import lsq_pkg::*; #(
	parameter int MAX_COLS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  row_width,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cell_bit,
	input  logic              last_cell,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SIDE_W-1:0] best_side,
	output logic [AREA_W-1:0] best_area
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int VW = $clog2(MAX_COLS + 1);

	logic [CFG_W-1:0] row_width_q;
	logic             in_accept;
	logic             s1_fire;
	logic             valid_s1;
	cell_ctl_t        ctl_s1;
	logic [CW-1:0]    col_s1;
	logic [CW-1:0]    rd_col;
	logic [VW-1:0]    up_data;
	logic [VW-1:0]    cell_val;
	logic             valid_s2;
	logic [VW-1:0]    side_s2;
	logic             s2_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			row_width_q <= row_width;
		end
	end

	assign in_stall  = valid_s1 & ~s1_fire;
	assign in_accept = in_valid & ~in_stall;

	lsq_col_track #(.MAX_COLS(MAX_COLS)) u_col_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.row_width_q (row_width_q),
		.in_accept   (in_accept),
		.cell_bit    (cell_bit),
		.last_cell   (last_cell),
		.s1_fire     (s1_fire),
		.rd_col      (rd_col),
		.col_s1      (col_s1),
		.ctl_s1      (ctl_s1),
		.valid_s1    (valid_s1)
	);

	lsq_line_buf #(.MAX_COLS(MAX_COLS)) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept),
		.rd_addr (rd_col),
		.wr_en   (s1_fire),
		.wr_addr (col_s1),
		.wr_data (cell_val),
		.up_data (up_data)
	);

	lsq_dp #(.MAX_COLS(MAX_COLS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.col_s1   (col_s1),
		.up_raw   (up_data),
		.s2_take  (s2_take),
		.s1_fire  (s1_fire),
		.cell_val (cell_val),
		.valid_s2 (valid_s2),
		.side_s2  (side_s2)
	);

	lsq_out #(.MAX_COLS(MAX_COLS)) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.side_s2   (side_s2),
		.out_stall (out_stall),
		.s2_take   (s2_take),
		.out_valid (out_valid),
		.best_side (best_side),
		.best_area (best_area)
	);

endmodule

>>> rtl/core/lsq_col_track.sv
module lsq_col_track import lsq_pkg::*; #(
	parameter int MAX_COLS = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [CFG_W-1:0]                      row_width_q,
	input  logic                                  in_accept,
	input  logic                                  cell_bit,
	input  logic                                  last_cell,
	input  logic                                  s1_fire,
	output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] rd_col,
	output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_s1,
	output cell_ctl_t                             ctl_s1,
	output logic                                  valid_s1
);

	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int MW  = $clog2(MAX_COLS + 1);
	localparam int WW  = (MW > CFG_W) ? MW : CFG_W;

	logic [CW-1:0] col_q;
	logic          first_q;
	logic [WW-1:0] w_eff;
	logic          wrap;
	logic [CW-1:0] col_eff;
	logic          first_eff;
	logic          end_row;

	always_comb begin
		if (row_width_q == '0) begin
			w_eff = WW'(1);
		end else if (WW'(row_width_q) > WW'(MAX_COLS)) begin
			w_eff = WW'(MAX_COLS);
		end else begin
			w_eff = WW'(row_width_q);
		end
	end

	// width shrunk mid-row: the cell starts a fresh row
	assign wrap      = WW'(col_q) >= w_eff;
	assign col_eff   = wrap ? '0 : col_q;
	assign first_eff = first_q & ~wrap;
	assign end_row   = (WW'(col_eff) + WW'(1)) >= w_eff;
	assign rd_col    = col_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			first_q  <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
				if (last_cell) begin
					col_q   <= '0;
					first_q <= 1'b1;
				end else if (end_row) begin
					col_q   <= '0;
					first_q <= 1'b0;
				end else begin
					col_q   <= CW'(col_eff + CW'(1));
					first_q <= first_eff;
				end
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			col_s1 <= col_eff;
			ctl_s1 <= '{is_set: cell_bit, last: last_cell, first: first_eff, end_row: end_row};
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && last_cell |=> col_q == '0 && first_q)
		else $error("column state not cleared after last cell");

endmodule

>>> rtl/core/lsq_line_buf.sv
module lsq_line_buf #(
	parameter int MAX_COLS = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rd_en,
	input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] rd_addr,
	input  logic                                  wr_en,
	input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] wr_addr,
	input  logic [$clog2(MAX_COLS + 1)-1:0]       wr_data,
	output logic [$clog2(MAX_COLS + 1)-1:0]       up_data
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int VW = $clog2(MAX_COLS + 1);

	logic [VW-1:0] mem [MAX_COLS];
	logic [VW-1:0] rd_q;
	logic [VW-1:0] byp_data_q;
	logic          byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// a write landing on the same edge as the read is forwarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign up_data = byp_q ? byp_data_q : rd_q;

	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en && (wr_addr == rd_addr) |=> up_data == $past(wr_data))
		else $error("same-edge write not forwarded to read");

endmodule

>>> rtl/core/lsq_dp.sv
module lsq_dp import lsq_pkg::*; #(
	parameter int MAX_COLS = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  valid_s1,
	input  cell_ctl_t                             ctl_s1,
	input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_s1,
	input  logic [$clog2(MAX_COLS + 1)-1:0]       up_raw,
	input  logic                                  s2_take,
	output logic                                  s1_fire,
	output logic [$clog2(MAX_COLS + 1)-1:0]       cell_val,
	output logic                                  valid_s2,
	output logic [$clog2(MAX_COLS + 1)-1:0]       side_s2
);

	localparam int VW = $clog2(MAX_COLS + 1);

	logic [VW-1:0] left_q;
	logic [VW-1:0] diag_q;
	logic [VW-1:0] best_q;
	logic [VW-1:0] up;
	logic [VW-1:0] m1;
	logic [VW-1:0] m2;
	logic [VW-1:0] best_new;
	logic          s2_free;

	assign up = ctl_s1.first ? '0 : up_raw;
	assign m1 = (up < left_q) ? up : left_q;
	assign m2 = (diag_q < m1) ? diag_q : m1;

	always_comb begin
		if (!ctl_s1.is_set) begin
			cell_val = '0;
		end else if (ctl_s1.first || col_s1 == '0) begin
			cell_val = VW'(1);
		end else begin
			cell_val = VW'(m2 + VW'(1));
		end
	end

	assign best_new = (cell_val > best_q) ? cell_val : best_q;

	// non-last cells leave no result, so only a last cell waits on stage 2
	assign s2_free = ~valid_s2 | s2_take;
	assign s1_fire = valid_s1 & (~ctl_s1.last | s2_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			diag_q   <= '0;
			best_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_fire) begin
				if (ctl_s1.last) begin
					left_q <= '0;
					diag_q <= '0;
					best_q <= '0;
				end else if (ctl_s1.end_row) begin
					left_q <= '0;
					diag_q <= '0;
					best_q <= best_new;
				end else begin
					left_q <= cell_val;
					diag_q <= up;
					best_q <= best_new;
				end
			end
			if (s1_fire && ctl_s1.last) begin
				valid_s2 <= 1'b1;
			end else if (s2_take) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && ctl_s1.last) begin
			side_s2 <= best_new;
		end
	end

	a_row_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && ctl_s1.end_row |=> left_q == '0 && diag_q == '0)
		else $error("neighbor values not cleared at end of row");

	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !ctl_s1.last |=> best_q >= $past(best_q))
		else $error("running best decreased within a matrix");

endmodule

>>> rtl/core/lsq_out.sv
module lsq_out import lsq_pkg::*; #(
	parameter int MAX_COLS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_s2,
	input  logic [$clog2(MAX_COLS + 1)-1:0] side_s2,
	input  logic                            out_stall,
	output logic                            s2_take,
	output logic                            out_valid,
	output logic [SIDE_W-1:0]               best_side,
	output logic [AREA_W-1:0]               best_area
);

	localparam int VW = $clog2(MAX_COLS + 1);
	localparam int PW = (2 * VW > AREA_W) ? 2 * VW : AREA_W;
	localparam int SW = (VW > SIDE_W) ? VW : SIDE_W;

	logic          out_valid_q;
	logic [PW-1:0] prod;
	logic [SW-1:0] side_ext;

	assign prod     = PW'(side_s2) * PW'(side_s2);
	assign side_ext = SW'(side_s2);
	assign s2_take  = valid_s2 & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take) begin
			best_side <= side_ext[SIDE_W-1:0];
			best_area <= prod[AREA_W-1:0];
		end
	end

	assign out_valid = out_valid_q;

	a_area_matches: assert property (@(posedge clk) disable iff (!arst_n)
		s2_take |=> out_valid && best_area == $past(prod[AREA_W-1:0]))
		else $error("area not loaded with its side");

endmodule
